### rtl/sfcc_pkg.sv
package sfcc_pkg;

   localparam int unsigned FRAME_DATA_BYTES = 8;
   localparam int unsigned FRAME_DONE       = 9;
   localparam logic [7:0]  CRC_POLY_REFL    = 8'h8C;
   localparam logic [7:0]  LIMIT_RESET      = 8'd10;
   localparam logic [7:0]  COUNT_MAX        = 8'hFF;

   // request kinds (tuser of the request side)
   localparam logic MODE_PRESENCE = 1'b0;
   localparam logic MODE_BYTE     = 1'b1;

   // presence outcomes
   localparam logic [1:0] PRES_OK      = 2'd0;
   localparam logic [1:0] PRES_NONE    = 2'd1;
   localparam logic [1:0] PRES_SHORTED = 2'd2;

   // register indexes
   localparam logic CSR_CRC_LIMIT     = 1'b0;
   localparam logic CSR_CONNECT_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      KIND_TEMP  = 2'd0,
      KIND_RETRY = 2'd1,
      KIND_ERROR = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_SHORT   = 2'd1,
      ERR_NO_DEV  = 2'd2,
      ERR_CRC     = 2'd3
   } error_code_type;

   typedef struct packed {
      logic [7:0]         computed_crc;
      logic signed [15:0] temperature_tenths;
      error_code_type     error_code;
      result_kind_type    result_kind;
   } rsp_type;

   // reflected crc-8, one byte, bit at a time
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/sensor_frame_crc_check_and_convert.sv
// channel  | dir | handshake               | payload
// ---------+-----+-------------------------+------------------------------------------
// req      | in  | req_tvalid / req_tready | tuser: mode; tdata: status, data byte
// rsp      | out | rsp_tvalid / rsp_tready | tuser: result kind; tdata: code, temp, crc
// csr      | in  | csr_valid / csr_ready   | csr_index, csr_data (8-bit limits)
//
// one request per cycle unless a held result stalls the request side: the frame state updates
// in the accepting cycle and any result lands in the output register on the next edge
// the crc byte update (eight shift/xor steps) and the shift-add x5 set the path
// reset is synchronous; limits come back at 10, counters and frame state at zero
// a held result blocks the request side only while rsp_tready stays low
module sensor_frame_crc_check_and_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] mode
   input  logic [15:0] req_tdata,   // [1:0] presence_status, [9:2] data_byte, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic [31:0] rsp_tdata,   // [1:0] error_code, [17:2] temperature_tenths,
                                    // [25:18] computed_crc, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   // configuration
   logic [7:0] crc_limit_ff, connect_limit_ff;

   // frame state
   logic [7:0] crc_acc_ff, crc_acc_in;
   logic [3:0] byte_pos_ff, byte_pos_in;
   logic [7:0] temp_lo_ff, temp_lo_in;
   logic [7:0] temp_hi_ff, temp_hi_in;
   logic [7:0] crc_fail_ff, crc_fail_in;
   logic [7:0] conn_fail_ff, conn_fail_in;

   // output register
   logic                 rsp_valid_ff;
   sfcc_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_load;

   logic       accept;
   logic       mode;
   logic [1:0] status;
   logic [7:0] data_byte;

   logic [7:0]  crc_next;
   logic [7:0]  conn_bumped, crc_bumped;
   logic [12:0] raw_q;
   logic [15:0] q_ext;
   logic [15:0] tenths;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign mode      = req_tuser;
   assign status    = req_tdata[1:0];
   assign data_byte = req_tdata[9:2];

   assign crc_next    = sfcc_pkg::crc8_update(crc_acc_ff, data_byte);
   assign conn_bumped = (conn_fail_ff == sfcc_pkg::COUNT_MAX) ? conn_fail_ff : conn_fail_ff + 8'd1;
   assign crc_bumped  = (crc_fail_ff == sfcc_pkg::COUNT_MAX) ? crc_fail_ff : crc_fail_ff + 8'd1;

   // raw >> 3 as a 13-bit signed value, times five by shift-add
   assign raw_q  = {temp_hi_ff, temp_lo_ff[7:3]};
   assign q_ext  = {{3{raw_q[12]}}, raw_q};
   assign tenths = (q_ext << 2) + q_ext;

   always_comb begin
      crc_acc_in   = crc_acc_ff;
      byte_pos_in  = byte_pos_ff;
      temp_lo_in   = temp_lo_ff;
      temp_hi_in   = temp_hi_ff;
      crc_fail_in  = crc_fail_ff;
      conn_fail_in = conn_fail_ff;
      rsp_load     = 1'b0;
      rsp_in.result_kind        = sfcc_pkg::KIND_TEMP;
      rsp_in.error_code         = sfcc_pkg::ERR_NONE;
      rsp_in.temperature_tenths = '0;
      rsp_in.computed_crc       = '0;

      if (mode == sfcc_pkg::MODE_PRESENCE) begin
         // any presence outcome aborts the frame
         byte_pos_in = '0;
         crc_acc_in  = '0;
         if (status != sfcc_pkg::PRES_OK) begin
            rsp_load = 1'b1;
            if (conn_bumped < connect_limit_ff) begin
               conn_fail_in       = conn_bumped;
               rsp_in.result_kind = sfcc_pkg::KIND_RETRY;
            end else begin
               conn_fail_in       = '0;
               rsp_in.result_kind = sfcc_pkg::KIND_ERROR;
               // status three counts as no sensor
               rsp_in.error_code  = (status == sfcc_pkg::PRES_SHORTED) ?
                                    sfcc_pkg::ERR_SHORT : sfcc_pkg::ERR_NO_DEV;
            end
         end
      end else if (byte_pos_ff < 4'(sfcc_pkg::FRAME_DATA_BYTES)) begin
         if (byte_pos_ff == 4'd0) begin
            temp_lo_in = data_byte;
         end
         if (byte_pos_ff == 4'd1) begin
            temp_hi_in = data_byte;
         end
         crc_acc_in  = crc_next;
         byte_pos_in = byte_pos_ff + 4'd1;
      end else if (byte_pos_ff == 4'(sfcc_pkg::FRAME_DATA_BYTES)) begin
         // check byte: exactly one result, then hold until next presence
         byte_pos_in         = 4'(sfcc_pkg::FRAME_DONE);
         rsp_load            = 1'b1;
         rsp_in.computed_crc = crc_acc_ff;
         if (data_byte != crc_acc_ff) begin
            if (crc_bumped < crc_limit_ff) begin
               crc_fail_in        = crc_bumped;
               rsp_in.result_kind = sfcc_pkg::KIND_RETRY;
            end else begin
               crc_fail_in        = '0;
               rsp_in.result_kind = sfcc_pkg::KIND_ERROR;
               rsp_in.error_code  = sfcc_pkg::ERR_CRC;
            end
         end else begin
            crc_fail_in               = '0;
            rsp_in.temperature_tenths = tenths;
         end
      end
      // bytes past the frame are dropped
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_limit_ff     <= sfcc_pkg::LIMIT_RESET;
         connect_limit_ff <= sfcc_pkg::LIMIT_RESET;
         crc_acc_ff       <= '0;
         byte_pos_ff      <= '0;
         temp_lo_ff       <= '0;
         temp_hi_ff       <= '0;
         crc_fail_ff      <= '0;
         conn_fail_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == sfcc_pkg::CSR_CRC_LIMIT) begin
               crc_limit_ff <= csr_data;
            end
            if (csr_index == sfcc_pkg::CSR_CONNECT_LIMIT) begin
               connect_limit_ff <= csr_data;
            end
         end
         if (accept) begin
            crc_acc_ff   <= crc_acc_in;
            byte_pos_ff  <= byte_pos_in;
            temp_lo_ff   <= temp_lo_in;
            temp_hi_ff   <= temp_hi_in;
            crc_fail_ff  <= crc_fail_in;
            conn_fail_ff <= conn_fail_in;
         end
         if (accept && rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept && rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.result_kind;
   assign rsp_tdata  = {6'd0, rsp_ff.computed_crc, rsp_ff.temperature_tenths, rsp_ff.error_code};

endmodule

### rtl/sfcc_checker.sv
module sfcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [31:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // the request side is open whenever the output register is free
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   // a temperature result carries no error code
   a_temp_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sfcc_pkg::KIND_TEMP |-> rsp_tdata[1:0] == sfcc_pkg::ERR_NONE)
      else $error("temperature result with error code");

   // temperature is zero on retry and error results
   a_temp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != sfcc_pkg::KIND_TEMP |-> rsp_tdata[17:2] == 16'd0)
      else $error("temperature set on non-temperature result");

   // retries never carry an error code
   a_retry_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sfcc_pkg::KIND_RETRY |-> rsp_tdata[1:0] == sfcc_pkg::ERR_NONE)
      else $error("retry with error code");

endmodule

bind sensor_frame_crc_check_and_convert sfcc_checker u_sfcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

### sim/frame_result_checker.sv
`timescale 1ns / 100ps

// watches the request, result and register channels, keeps its own copy of the
// frame state and compares every result with the oldest expected reading
module frame_result_checker
   import sfcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tuser,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [1:0]  rsp_tuser,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending_readings
);

   typedef struct {
      result_kind_type    kind;
      error_code_type     code;
      logic signed [15:0] tenths;
      logic [7:0]         crc;
   } reading_type;

   reading_type expected_readings[$];
   reading_type want;
   logic [7:0] crc_limit;
   logic [7:0] connect_limit;
   logic [7:0] crc_sum;
   logic [7:0] temp_lo;
   logic [7:0] temp_hi;
   logic [7:0] crc_misses;
   logic [7:0] connect_misses;
   logic [3:0] byte_index;

   // reflected crc, one data bit per step, lsb first
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] value);
      logic [7:0] acc;
      logic       fb;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ value[i];
         acc = acc >> 1;
         if (fb) begin
            acc = acc ^ CRC_POLY_REFL;
         end
      end
      return acc;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
      $display("%t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
      fail_count++;
   endtask

   task automatic predict(input logic mode, input logic [1:0] status, input logic [7:0] value);
      reading_type        r;
      logic signed [15:0] raw;
      r = '{kind: KIND_TEMP, code: ERR_NONE, tenths: 16'sd0, crc: 8'd0};
      if (mode == MODE_PRESENCE) begin
         // any presence event aborts the frame
         byte_index = 4'd0;
         crc_sum    = 8'd0;
         if (status != PRES_OK) begin
            if (connect_misses != COUNT_MAX) begin
               connect_misses = connect_misses + 8'd1;
            end
            if (connect_misses < connect_limit) begin
               r.kind = KIND_RETRY;
            end else begin
               connect_misses = 8'd0;
               r.kind = KIND_ERROR;
               r.code = (status == PRES_SHORTED) ? ERR_SHORT : ERR_NO_DEV;
            end
            expected_readings.push_back(r);
         end
      end else if (byte_index < 4'(FRAME_DATA_BYTES)) begin
         if (byte_index == 4'd0) begin
            temp_lo = value;
         end else if (byte_index == 4'd1) begin
            temp_hi = value;
         end
         crc_sum    = crc_step(crc_sum, value);
         byte_index = byte_index + 4'd1;
      end else if (byte_index == 4'(FRAME_DATA_BYTES)) begin
         byte_index = 4'(FRAME_DONE);
         r.crc = crc_sum;
         if (value != crc_sum) begin
            if (crc_misses != COUNT_MAX) begin
               crc_misses = crc_misses + 8'd1;
            end
            if (crc_misses < crc_limit) begin
               r.kind = KIND_RETRY;
            end else begin
               crc_misses = 8'd0;
               r.kind = KIND_ERROR;
               r.code = ERR_CRC;
            end
         end else begin
            crc_misses = 8'd0;
            raw = {temp_hi, temp_lo};
            r.tenths = (raw >>> 3) * 16'sd5;
         end
         expected_readings.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_readings.delete();
         fail_count     = 0;
         crc_limit      = LIMIT_RESET;
         connect_limit  = LIMIT_RESET;
         crc_sum        = 8'd0;
         temp_lo        = 8'd0;
         temp_hi        = 8'd0;
         crc_misses     = 8'd0;
         connect_misses = 8'd0;
         byte_index     = 4'd0;
      end else begin
         // a result never stems from a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               report("result with nothing pending", {30'd0, rsp_tuser}, 32'd0);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_tuser !== want.kind) begin
                  report("result_kind", 32'(rsp_tuser), 32'(want.kind));
               end
               if (rsp_tdata[1:0] !== want.code) begin
                  report("error_code", 32'(rsp_tdata[1:0]), 32'(want.code));
               end
               if (rsp_tdata[17:2] !== want.tenths) begin
                  report("temperature_tenths", 32'(rsp_tdata[17:2]),
                         32'(16'(want.tenths)));
               end
               if (rsp_tdata[25:18] !== want.crc) begin
                  report("computed_crc", 32'(rsp_tdata[25:18]), 32'(want.crc));
               end
               if (rsp_tdata[31:26] !== 6'd0) begin
                  report("tdata padding", 32'(rsp_tdata[31:26]), 32'd0);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict(req_tuser, req_tdata[1:0], req_tdata[9:2]);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CRC_LIMIT) begin
               crc_limit = csr_data;
            end else begin
               connect_limit = csr_data;
            end
         end
      end
      pending_readings = expected_readings.size();
   end

endmodule

### sim/sensor_frame_crc_check_and_convert_tb.sv
`timescale 1ns / 100ps

// stimulus and verdict for the scratchpad frame checker; the checker instance
// does all prediction and comparison and hands back its failure count
module sensor_frame_crc_check_and_convert_tb;
   import sfcc_pkg::*;

   // status code the bus never reports on purpose, the block treats it as no sensor
   localparam logic [1:0] PRES_UNDEFINED = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser  = 1'b0;   // [0] mode
   logic [15:0] req_tdata  = 16'd0;  // [1:0] presence_status, [9:2] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;           // [1:0] result_kind
   logic [31:0] rsp_tdata;           // [1:0] error_code, [17:2] tenths, [25:18] crc
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [7:0]  csr_data   = 8'd0;

   int          fail_count;
   int          pending_readings;
   int          sent_items = 0;
   int unsigned rsp_stall  = 0;
   int unsigned rsp_hold;
   bit          req_calm   = 1'b0;   // no gaps between requests while set
   bit          rsp_calm   = 1'b0;   // no result stalls while set

   always #4 clock = ~clock;

   sensor_frame_crc_check_and_convert DUT (.*);

   frame_result_checker u_check (.*);

   // result side: after each taken result hold tready low for a random stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_hold = rsp_calm ? 0 : $urandom_range(0, 11);
         if (rsp_hold != 0) begin
            rsp_tready <= 1'b0;
            rsp_stall  <= rsp_hold;
         end
      end else if (!rsp_tready) begin
         if (rsp_stall <= 1) begin
            rsp_tready <= 1'b1;
         end
         rsp_stall <= rsp_stall - 1;
      end
   end

   // stimulus crc, byte wise with the polynomial folded in per bit
   function automatic logic [7:0] scratchpad_crc(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   // one request; returns just after the edge that took it, tvalid still high
   task automatic send_req(input logic mode, input logic [1:0] status, input logic [7:0] b);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'd0, b, status};
      // tready settles by the falling edge, so check there and take the next rise
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      sent_items++;
   endtask

   // good presence, then n_bytes of the frame; the ninth byte is the crc
   task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi,
                             input int unsigned n_bytes, input bit corrupt);
      logic [7:0] crc;
      logic [7:0] b;
      crc = 8'd0;
      send_req(MODE_PRESENCE, PRES_OK, 8'($urandom_range(0, 255)));
      for (int i = 0; i < 8 && i < n_bytes; i++) begin
         b = (i == 0) ? lo : (i == 1) ? hi : 8'($urandom_range(0, 255));
         crc = scratchpad_crc(crc, b);
         send_req(MODE_BYTE, 2'($urandom_range(0, 3)), b);
      end
      if (n_bytes > 8) begin
         if (corrupt) begin
            crc = crc ^ 8'($urandom_range(1, 255));
         end
         send_req(MODE_BYTE, 2'($urandom_range(0, 3)), crc);
      end
   endtask

   // bytes past the crc byte are dropped by the block and do not count as items
   task automatic send_trailing(input int unsigned n);
      repeat (n) begin
         send_req(MODE_BYTE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         sent_items--;
      end
   endtask

   task automatic random_event();
      int unsigned pick;
      int unsigned n_bytes;
      logic [15:0] raw;
      req_calm = ($urandom_range(0, 4) == 0);
      rsp_calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // noise: anything the fields allow
         send_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)));
      end else if (pick < 20) begin
         // failed presence, aborts any frame in progress
         send_req(MODE_PRESENCE, 2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 7))
            0: raw = 16'h8000;
            1: raw = 16'h7FFF;
            2: raw = 16'($urandom_range(0, 15)) | 16'hFFF0;
            3: raw = 16'($urandom_range(0, 15));
            default: raw = 16'($urandom_range(0, 65535));
         endcase
         // now and then a frame cut short by the next event
         n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 9;
         send_frame(raw[7:0], raw[15:8], n_bytes, $urandom_range(0, 3) == 0);
         if (n_bytes == 9 && $urandom_range(0, 9) == 0) begin
            send_trailing($urandom_range(1, 3));
         end
      end
   endtask

   // drop tvalid and let every expected result drain before touching registers
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_readings != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both limits in one burst, csr_valid held across the two writes
   task automatic write_limits(input logic [7:0] crc_lim, input logic [7:0] connect_lim);
      csr_valid <= 1'b1;
      csr_index <= CSR_CRC_LIMIT;
      csr_data  <= crc_lim;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_index <= CSR_CONNECT_LIMIT;
      csr_data  <= connect_lim;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int         phase_end;
      logic [7:0] crc_lims [6];
      logic [7:0] connect_lims [6];
      // 255 first so counts build up, then lower limits hit counts already past them;
      // zero reports an error on the first failure
      crc_lims     = '{8'd255, 8'd3, 8'd1, 8'd0, 8'd2, 8'($urandom_range(1, 6))};
      connect_lims = '{8'd255, 8'd2, 8'd1, 8'd0, 8'd4, 8'($urandom_range(1, 6))};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, limits still at their reset value
      // coldest reading, good crc
      send_frame(8'h00, 8'h80, 9, 1'b0);
      // byte after a finished frame is ignored
      send_req(MODE_BYTE, PRES_OK, 8'hFF);
      // hottest reading, good crc
      send_frame(8'hFF, 8'h7F, 9, 1'b0);
      // presence failures: no sensor, short to ground, the undefined status
      send_req(MODE_PRESENCE, PRES_NONE, 8'h00);
      send_req(MODE_PRESENCE, PRES_SHORTED, 8'hFF);
      send_req(MODE_PRESENCE, PRES_UNDEFINED, 8'hA5);

      // random phases, each under its own pair of limits
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_limits(crc_lims[p], connect_lims[p]);
         phase_end = sent_items + 63;
         while (sent_items < phase_end) random_event();
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("sensor_frame_crc_check_and_convert_tb: PASS");
      end else begin
         $display("sensor_frame_crc_check_and_convert_tb: FAIL");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("sensor_frame_crc_check_and_convert_tb: FAIL");
      $finish;
   end

endmodule
